FILE: sv/assert_macros.svh
// Assertion macros shared by the tuning-word sequencer RTL.
// Each macro expands to one labeled concurrent assertion with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dtws_pkg.sv
// Shared types and constants for the DDS tuning-word write sequencer.
// No dependencies; every other file but assert_macros.svh imports this package.
package dtws_pkg;

    localparam int FREQ_W   = 32;
    localparam int AMP_W    = 12;
    localparam int MULT_W   = 24;
    localparam int CLKSET_W = 8;
    localparam int FTW_W    = 48;
    localparam int PROD_W   = FREQ_W + MULT_W;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 8;
    localparam int CFG_W    = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MULT_W-1:0]   FREQ_MULT_RESET = 24'd1005268;
    localparam logic [CLKSET_W-1:0] CLKSET_RESET    = 8'h04;

    // Configuration register indexes.
    localparam logic CFG_FREQ_MULT = 1'b0;
    localparam logic CFG_CLKSET    = 1'b1;

    // Command kinds.
    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_INIT = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_RESET  = 2'd2
    } t_op;

    // Device register addresses and fixed init data.
    localparam logic [ADDR_W-1:0] ADDR_FTW_BASE = 6'h04;
    localparam logic [ADDR_W-1:0] ADDR_I_HI     = 6'h21;
    localparam logic [ADDR_W-1:0] ADDR_I_LO     = 6'h22;
    localparam logic [ADDR_W-1:0] ADDR_Q_HI     = 6'h23;
    localparam logic [ADDR_W-1:0] ADDR_Q_LO     = 6'h24;
    localparam logic [ADDR_W-1:0] ADDR_CTRL_A   = 6'h1D;
    localparam logic [ADDR_W-1:0] ADDR_CLKMUL   = 6'h1E;
    localparam logic [ADDR_W-1:0] ADDR_CTRL_C   = 6'h1F;
    localparam logic [ADDR_W-1:0] ADDR_CTRL_D   = 6'h20;
    localparam logic [DATA_W-1:0] DATA_CTRL_A   = 8'h10;
    localparam logic [DATA_W-1:0] DATA_CTRL_C   = 8'h00;
    localparam logic [DATA_W-1:0] DATA_CTRL_D   = 8'h60;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_SET_LAST  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_INIT_LAST = 4'd5;

    // One classified command, as queued between front and back.
    typedef struct packed {
        logic             kind;
        logic [FTW_W-1:0] ftw;
        logic [AMP_W-1:0] amp;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_xfer;

endpackage

FILE: sv/dtws_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
// Depends on dtws_pkg for field widths.
interface dtws_cmd_if
    import dtws_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [FREQ_W-1:0] frequency;
    logic [AMP_W-1:0]  amplitude;

    modport source (output valid, kind, frequency, amplitude, input ready);
    modport sink   (input valid, kind, frequency, amplitude, output ready);
endinterface

FILE: sv/dtws_res_if.sv
// Result channel: valid/ready handshake carrying one bus operation word.
// Depends on dtws_pkg for field widths and the operation type.
interface dtws_res_if
    import dtws_pkg::*;
;
    logic              valid;
    logic              ready;
    t_op               operation;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              last;

    modport source (output valid, operation, write_address, write_data, last, input ready);
    modport sink   (input valid, operation, write_address, write_data, last, output ready);
endinterface

FILE: sv/dds_tuning_word_write_sequencer.sv
// A command's first word passes the multiply register, the queue and the output
// register. The sequencer emits one word per cycle while the result channel is
// ready; a set command gives 11 words, an init command 6. A queue of 2 commands
// plus one multiply stage sits between command input and the sequencer.
// Reset (synchronous, active low) empties the pipeline and restores the multiplier
// and clock setting registers to their defaults.
module dds_tuning_word_write_sequencer
    import dtws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dtws_cmd_if.sink         i_cmd,
    dtws_res_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [MULT_W-1:0]   r_freq_mult;
    logic [CLKSET_W-1:0] r_clkset;

    t_job_xfer w_push;
    t_job_xfer w_head;
    logic      w_full;
    logic      w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_mult <= FREQ_MULT_RESET;
            r_clkset    <= CLKSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FREQ_MULT: r_freq_mult <= i_cfg_data[MULT_W-1:0];
                CFG_CLKSET:    r_clkset    <= i_cfg_data[CLKSET_W-1:0];
                default:       r_clkset    <= r_clkset;
            endcase
        end
    end

    dtws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_freq_mult  (r_freq_mult),
        .o_push       (w_push),
        .i_queue_full (w_full)
    );

    dtws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    dtws_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .i_clkset (r_clkset),
        .o_res    (o_res)
    );

endmodule

FILE: sv/dtws_queue.sv
// Short job queue that decouples the command front from the bus sequencer.
// Depends on dtws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtws_queue
    import dtws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_xfer i_push,
    output logic      o_full,
    output t_job_xfer o_head,
    input  logic      i_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push      = i_push.valid && !o_full;
    assign w_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `ASSERT_CLK(a_pop_nonempty, i_clk, i_rst_n, !i_pop || o_head.valid, "pop from empty queue")
    `ASSERT_CLK(a_push_gated, i_clk, i_rst_n, !(i_push.valid && o_full) || !w_push, "push into full queue")

endmodule

FILE: sv/dtws_front.sv
// Command front: accepts command words and forms the 48-bit tuning word.
// Depends on dtws_pkg and the command channel interface.
module dtws_front
    import dtws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dtws_cmd_if.sink          i_cmd,
    input  logic [MULT_W-1:0] i_freq_mult,
    output t_job_xfer         o_push,
    input  logic              i_queue_full
);

    logic              r_valid;
    t_job              r_job;
    logic [PROD_W-1:0] w_prod;
    logic              w_accept;

    // The stage drains into the queue whenever the queue has room.
    assign i_cmd.ready = !r_valid || !i_queue_full;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_prod      = PROD_W'(i_cmd.frequency) * PROD_W'(i_freq_mult);

    assign o_push.valid = r_valid;
    assign o_push.job   = r_job;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job.kind <= i_cmd.kind;
            r_job.ftw  <= w_prod[FTW_W-1:0];
            r_job.amp  <= i_cmd.amplitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_queue_full) begin
            r_valid <= 1'b0;
        end
    end

endmodule

FILE: sv/dtws_back.sv
// Bus sequencer: expands the job at the queue head into bus operation words.
// Depends on dtws_pkg and the result channel interface.
module dtws_back
    import dtws_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_job_xfer           i_head,
    output logic                o_pop,
    input  logic [CLKSET_W-1:0] i_clkset,
    dtws_res_if.source          o_res
);

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic              r_last;

    logic              w_emit;
    logic              w_final;
    t_op               n_op;
    logic [ADDR_W-1:0] n_addr;
    logic [DATA_W-1:0] n_data;
    logic [DATA_W-1:0] w_amp_hi;
    logic [DATA_W-1:0] w_amp_lo;

    assign w_emit   = i_head.valid && (!r_out_valid || o_res.ready);
    assign w_final  = (i_head.job.kind == KIND_INIT) ? (r_step == STEP_INIT_LAST)
                                                     : (r_step == STEP_SET_LAST);
    assign o_pop    = w_emit && w_final;
    assign w_amp_hi = DATA_W'(i_head.job.amp[AMP_W-1:DATA_W]);
    assign w_amp_lo = i_head.job.amp[DATA_W-1:0];

    always_comb begin
        n_op   = OP_WRITE;
        n_addr = '0;
        n_data = '0;
        if (i_head.job.kind == KIND_INIT) begin
            case (r_step)
                4'd0: n_op = OP_RESET;
                4'd1: begin n_addr = ADDR_CTRL_A; n_data = DATA_CTRL_A; end
                4'd2: begin n_addr = ADDR_CLKMUL; n_data = i_clkset;    end
                4'd3: begin n_addr = ADDR_CTRL_C; n_data = DATA_CTRL_C; end
                4'd4: begin n_addr = ADDR_CTRL_D; n_data = DATA_CTRL_D; end
                default: n_op = OP_UPDATE;
            endcase
        end else begin
            // Tuning-word bytes go out most significant first.
            case (r_step)
                4'd0: begin n_addr = ADDR_FTW_BASE;        n_data = i_head.job.ftw[47:40]; end
                4'd1: begin n_addr = ADDR_FTW_BASE + 6'd1; n_data = i_head.job.ftw[39:32]; end
                4'd2: begin n_addr = ADDR_FTW_BASE + 6'd2; n_data = i_head.job.ftw[31:24]; end
                4'd3: begin n_addr = ADDR_FTW_BASE + 6'd3; n_data = i_head.job.ftw[23:16]; end
                4'd4: begin n_addr = ADDR_FTW_BASE + 6'd4; n_data = i_head.job.ftw[15:8];  end
                4'd5: begin n_addr = ADDR_FTW_BASE + 6'd5; n_data = i_head.job.ftw[7:0];   end
                4'd6: begin n_addr = ADDR_I_HI; n_data = w_amp_hi; end
                4'd7: begin n_addr = ADDR_I_LO; n_data = w_amp_lo; end
                4'd8: begin n_addr = ADDR_Q_HI; n_data = w_amp_hi; end
                4'd9: begin n_addr = ADDR_Q_LO; n_data = w_amp_lo; end
                default: n_op = OP_UPDATE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_op   <= n_op;
            r_addr <= n_addr;
            r_data <= n_data;
            r_last <= w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_step      <= w_final ? '0 : r_step + 1'b1;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.operation     = r_op;
    assign o_res.write_address = r_addr;
    assign o_res.write_data    = r_data;
    assign o_res.last          = r_last;

endmodule
